/* rtl/core/mandelbrot_escape_pixel_core_macros.svh */
// Assertion macros shared by the escape-time pixel core modules.
`ifndef MANDELBROT_ESCAPE_PIXEL_CORE_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Condition holds in the same cycle as the trigger
`define MEP_ASSERT_IMP(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("check failed: same-cycle implication");
// Condition holds in the cycle after the trigger
`define MEP_ASSERT_NXT(lbl, clk, rst_n, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("check failed: next-cycle implication");
`else
`define MEP_ASSERT_IMP(lbl, clk, rst_n, trig, cond)
`define MEP_ASSERT_NXT(lbl, clk, rst_n, trig, cond)
`endif
`endif

/* rtl/core/mep_pkg.sv */
// Shared types, constants and helpers of the escape-time pixel core.
package mep_pkg;

  // Field and datapath widths
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned GLYPH_W    = 5;
  localparam int unsigned Z_W        = 32;
  localparam int unsigned PROD_W     = 64;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;

  // Parameter defaults
  localparam int unsigned FRACTION_BITS_DEF = 28;
  localparam int unsigned GLYPH_STEPS_DEF   = 20;

  // Register indexes on the configuration port
  localparam logic [CFG_ADDR_W-1:0] CFG_START_REAL = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_START_IMAG = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_REAL  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_IMAG  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_ITER_LIMIT = 3'd4;

  // Register values after reset
  localparam logic signed [Z_W-1:0] START_REAL_RST = -32'sd536870912;
  localparam logic signed [Z_W-1:0] START_IMAG_RST = 32'sd268435456;
  localparam logic [STEP_W-1:0]     STEP_REAL_RST  = 31'd20132659;
  localparam logic [STEP_W-1:0]     STEP_IMAG_RST  = 31'd26843545;
  localparam logic [IDX_W-1:0]      ITER_LIMIT_RST = 12'd20;

  // Status of the glyph divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [Z_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    logic signed [Z_W-1:0] res;
    if ((v[PROD_W-1:Z_W-1] == '0) || (v[PROD_W-1:Z_W-1] == '1)) begin
      res = v[Z_W-1:0];
    end else if (v[PROD_W-1]) begin
      res = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(Z_W-1){1'b1}}};
    end
    return res;
  endfunction

  // Sign-extend a 32-bit value to product width
  function automatic logic signed [PROD_W-1:0] sext(input logic signed [Z_W-1:0] v);
    return {{(PROD_W-Z_W){v[Z_W-1]}}, v};
  endfunction

endpackage

/* rtl/core/mep_mult.sv */
// Shared signed 32 by 32 multiplier with a registered product.
module mep_mult (
  input  logic                              clk,
  input  logic signed [mep_pkg::Z_W-1:0]    a,
  input  logic signed [mep_pkg::Z_W-1:0]    b,
  output logic signed [mep_pkg::PROD_W-1:0] prod_r
);

  logic signed [mep_pkg::PROD_W-1:0] prod_nxt;

  // Full-width product of the selected operands
  always_comb begin
    prod_nxt = mep_pkg::sext(a) * mep_pkg::sext(b);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

/* rtl/core/mep_glyph_div.sv */
// Restoring divider, one quotient bit per cycle, for the glyph index.
`include "mandelbrot_escape_pixel_core_macros.svh"
module mep_glyph_div #(
  parameter  int unsigned QUO_W = 5,
  parameter  int unsigned DEN_W = 12,
  localparam int unsigned NUM_W = DEN_W + QUO_W,
  localparam int unsigned CNT_W = $clog2(QUO_W + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [NUM_W-1:0]          numer,
  input  logic [DEN_W-1:0]          denom,
  output mep_pkg::div_stat_t        stat,
  output logic [QUO_W-1:0]          quo
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic             fits;

  assign fits = (rem_r >= dsh_r);

  // Load operands, then take one quotient bit per cycle, highest first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (busy_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quo_nxt = (quo_r << 1) | QUO_W'(fits);
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(QUO_W);
      rem_nxt  = numer;
      dsh_nxt  = NUM_W'(denom) << (QUO_W - 1);
      quo_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = quo_r;

  `MEP_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy_r, busy_r)
  `MEP_ASSERT_IMP(a_busy_count, clk, rst_n, busy_r, cnt_r != '0)
  `MEP_ASSERT_NXT(a_done_pulse, clk, rst_n, done_r, !done_r)

endmodule

/* rtl/core/mandelbrot_escape_pixel_core.sv */
// Top level of the fixed-point escape-time pixel core: sequencer and datapath.
//
// Usage: each input item carries a pixel column and row on in_tdata. The core
// maps it to c = (start_real + column*step_real, start_imag - row*step_imag),
// iterates z = z*z + c from zero up to iteration_limit times and returns one
// item per pixel on out_tdata: iteration count, escaped flag and glyph index.
// Registers are to be written over the cfg_ port only while the core is idle;
// the core does not enforce this. One signed 32x32 multiplier is shared by
// every product; each escape pass runs the cross product, the update and two
// squares with the magnitude test. After acceptance the core forms c, runs
// the passes and the glyph division (both skipped for a zero limit) and loads
// the result; the next item can be taken in the cycle after it is loaded.
// in_tready is high only while the core is idle; a result waiting in the output
// register does not block a new item, but a finished item waits for the output
// register to empty when the receiver stalls.
// Reset (synchronous, active low) restores the register defaults, clears the
// sequencer and drops out_tvalid.
`include "mandelbrot_escape_pixel_core_macros.svh"
module mandelbrot_escape_pixel_core #(
  parameter int unsigned FRACTION_BITS = mep_pkg::FRACTION_BITS_DEF,
  parameter int unsigned GLYPH_STEPS   = mep_pkg::GLYPH_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [mep_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [mep_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  // Input items
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mep_pkg::IN_DATA_W-1:0]        in_tdata,   // column[11:0], row[23:12]
  // Result items
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mep_pkg::OUT_DATA_W-1:0]       out_tdata   // iterations[11:0], escaped[12],
                                                           // glyph_index[17:13], zero pad
);

  localparam int unsigned QUO_W     = $clog2(GLYPH_STEPS + 1);
  localparam int unsigned NUM_W     = mep_pkg::IDX_W + QUO_W;
  localparam int unsigned THR_SHIFT = 2 * FRACTION_BITS + 2;
  localparam bit          ESC_EN    = (THR_SHIFT < mep_pkg::PROD_W);
  localparam logic [mep_pkg::PROD_W-1:0] THRESH =
    ESC_EN ? (64'd1 << (THR_SHIFT % mep_pkg::PROD_W)) : '1;
  localparam int unsigned OUT_PAD   = mep_pkg::OUT_DATA_W - mep_pkg::IDX_W - 1 - mep_pkg::GLYPH_W;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_CR   = 12'b0000_0000_0010,
    S_CI   = 12'b0000_0000_0100,
    S_CIW  = 12'b0000_0000_1000,
    S_RI   = 12'b0000_0001_0000,
    S_UPD  = 12'b0000_0010_0000,
    S_RR   = 12'b0000_0100_0000,
    S_II   = 12'b0000_1000_0000,
    S_MAG  = 12'b0001_0000_0000,
    S_DIV  = 12'b0010_0000_0000,
    S_DIVW = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_t;

  // Configuration registers
  logic signed [mep_pkg::Z_W-1:0]    start_real_r, start_imag_r;
  logic [mep_pkg::STEP_W-1:0]        step_real_r, step_imag_r;
  logic [mep_pkg::IDX_W-1:0]         limit_r;

  // Sequencer and datapath registers
  state_t                            state_r, state_nxt;
  logic [mep_pkg::IDX_W-1:0]         col_r, col_nxt;
  logic [mep_pkg::IDX_W-1:0]         row_r, row_nxt;
  logic signed [mep_pkg::Z_W-1:0]    cr_r, cr_nxt;
  logic signed [mep_pkg::Z_W-1:0]    ci_r, ci_nxt;
  logic signed [mep_pkg::Z_W-1:0]    zr_r, zr_nxt;
  logic signed [mep_pkg::Z_W-1:0]    zi_r, zi_nxt;
  logic signed [mep_pkg::PROD_W-1:0] rr_r, rr_nxt;
  logic signed [mep_pkg::PROD_W-1:0] ii_r, ii_nxt;
  logic [mep_pkg::IDX_W-1:0]         iter_r, iter_nxt;
  logic                              esc_r, esc_nxt;
  logic [mep_pkg::GLYPH_W-1:0]       glyph_r, glyph_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic [mep_pkg::IDX_W-1:0]         out_iter_r, out_iter_nxt;
  logic                              out_esc_r, out_esc_nxt;
  logic [mep_pkg::GLYPH_W-1:0]       out_glyph_r, out_glyph_nxt;

  // Shared multiplier and glyph divider
  logic signed [mep_pkg::Z_W-1:0]    mul_a, mul_b;
  logic signed [mep_pkg::PROD_W-1:0] prod;
  logic                              div_start;
  logic [NUM_W-1:0]                  div_numer;
  mep_pkg::div_stat_t                div_stat;
  logic [QUO_W-1:0]                  div_quo;

  // Update terms
  logic signed [mep_pkg::PROD_W-1:0] re_sum, im_sum;
  logic signed [mep_pkg::PROD_W-1:0] cr_sum, ci_sum;
  logic [mep_pkg::PROD_W-1:0]        mag;
  logic                              in_acc;
  logic                              esc_hit;

  assign in_acc = in_tvalid && in_tready;

  mep_mult u_mult (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  mep_glyph_div #(
    .QUO_W (QUO_W),
    .DEN_W (mep_pkg::IDX_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (div_numer),
    .denom (limit_r),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_real_r <= mep_pkg::START_REAL_RST;
      start_imag_r <= mep_pkg::START_IMAG_RST;
      step_real_r  <= mep_pkg::STEP_REAL_RST;
      step_imag_r  <= mep_pkg::STEP_IMAG_RST;
      limit_r      <= mep_pkg::ITER_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        mep_pkg::CFG_START_REAL: start_real_r <= cfg_wdata;
        mep_pkg::CFG_START_IMAG: start_imag_r <= cfg_wdata;
        mep_pkg::CFG_STEP_REAL:  step_real_r  <= cfg_wdata[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_STEP_IMAG:  step_imag_r  <= cfg_wdata[mep_pkg::STEP_W-1:0];
        mep_pkg::CFG_ITER_LIMIT: limit_r      <= cfg_wdata[mep_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Select multiplier operands for the current step
  always_comb begin
    case (state_r)
      S_CR: begin
        mul_a = {{(mep_pkg::Z_W-mep_pkg::IDX_W){1'b0}}, col_r};
        mul_b = {1'b0, step_real_r};
      end
      S_CI: begin
        mul_a = {{(mep_pkg::Z_W-mep_pkg::IDX_W){1'b0}}, row_r};
        mul_b = {1'b0, step_imag_r};
      end
      S_RR: begin
        mul_a = zr_r;
        mul_b = zr_r;
      end
      S_II: begin
        mul_a = zi_r;
        mul_b = zi_r;
      end
      default: begin
        mul_a = zr_r;
        mul_b = zi_r;
      end
    endcase
  end

  // Coordinate sums, z update terms and escape test
  assign cr_sum  = mep_pkg::sext(start_real_r) + prod;
  assign ci_sum  = mep_pkg::sext(start_imag_r) - prod;
  assign re_sum  = ((rr_r - ii_r) >>> FRACTION_BITS) + mep_pkg::sext(cr_r);
  assign im_sum  = (prod >>> (FRACTION_BITS - 1)) + mep_pkg::sext(ci_r);
  assign mag     = rr_r + prod;
  assign esc_hit = ESC_EN && (mag > THRESH);

  assign div_start = (state_r == S_DIV);
  assign div_numer = NUM_W'(iter_r) * NUM_W'(GLYPH_STEPS);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    cr_nxt        = cr_r;
    ci_nxt        = ci_r;
    zr_nxt        = zr_r;
    zi_nxt        = zi_r;
    rr_nxt        = rr_r;
    ii_nxt        = ii_r;
    iter_nxt      = iter_r;
    esc_nxt       = esc_r;
    glyph_nxt     = glyph_r;
    out_valid_nxt = out_valid_r;
    out_iter_nxt  = out_iter_r;
    out_esc_nxt   = out_esc_r;
    out_glyph_nxt = out_glyph_r;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          col_nxt   = in_tdata[mep_pkg::IDX_W-1:0];
          row_nxt   = in_tdata[2*mep_pkg::IDX_W-1:mep_pkg::IDX_W];
          state_nxt = S_CR;
        end
      end
      S_CR: begin
        state_nxt = S_CI;
      end
      S_CI: begin
        cr_nxt    = mep_pkg::sat32(cr_sum);
        state_nxt = S_CIW;
      end
      S_CIW: begin
        ci_nxt   = mep_pkg::sat32(ci_sum);
        zr_nxt   = '0;
        zi_nxt   = '0;
        rr_nxt   = '0;
        ii_nxt   = '0;
        iter_nxt = '0;
        if (limit_r == '0) begin
          esc_nxt   = 1'b0;
          glyph_nxt = mep_pkg::GLYPH_W'(GLYPH_STEPS);
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_RI;
        end
      end
      S_RI: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        zr_nxt    = mep_pkg::sat32(re_sum);
        zi_nxt    = mep_pkg::sat32(im_sum);
        state_nxt = S_RR;
      end
      S_RR: begin
        state_nxt = S_II;
      end
      S_II: begin
        rr_nxt    = prod;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        // Cross product of the new z is issued here for the next pass
        ii_nxt = prod;
        if (esc_hit) begin
          esc_nxt   = 1'b1;
          state_nxt = S_DIV;
        end else if (iter_r == limit_r - mep_pkg::IDX_W'(1)) begin
          esc_nxt   = 1'b0;
          iter_nxt  = limit_r;
          state_nxt = S_DIV;
        end else begin
          iter_nxt  = iter_r + mep_pkg::IDX_W'(1);
          state_nxt = S_UPD;
        end
      end
      S_DIV: begin
        state_nxt = S_DIVW;
      end
      S_DIVW: begin
        if (div_stat.done) begin
          glyph_nxt = mep_pkg::GLYPH_W'(div_quo);
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_iter_nxt  = iter_r;
          out_esc_nxt   = esc_r;
          out_glyph_nxt = glyph_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r       <= col_nxt;
    row_r       <= row_nxt;
    cr_r        <= cr_nxt;
    ci_r        <= ci_nxt;
    zr_r        <= zr_nxt;
    zi_r        <= zi_nxt;
    rr_r        <= rr_nxt;
    ii_r        <= ii_nxt;
    iter_r      <= iter_nxt;
    esc_r       <= esc_nxt;
    glyph_r     <= glyph_nxt;
    out_iter_r  <= out_iter_nxt;
    out_esc_r   <= out_esc_nxt;
    out_glyph_r <= out_glyph_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_glyph_r, out_esc_r, out_iter_r};

  `MEP_ASSERT_NXT(a_accept_start, clk, rst_n, in_acc, state_r == S_CR)
  `MEP_ASSERT_IMP(a_iter_bound, clk, rst_n, state_r == S_MAG, iter_r < limit_r)
  `MEP_ASSERT_IMP(a_div_idle, clk, rst_n, state_r == S_DIV, !div_stat.busy)
  `MEP_ASSERT_IMP(a_esc_count, clk, rst_n, (state_r == S_OUT) && esc_r, iter_r < limit_r)

endmodule
